FILE: hw/rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands with an active-low reset disable.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ULA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// Check that a condition is followed by another in the next cycle.
`define ULA_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

FILE: hw/rtl/ula_pkg.sv
// -----------------------------------------------------------------------------
// ula_pkg
// Shared types, codes and defaults of the UART line assembler ring.
// -----------------------------------------------------------------------------
package ula_pkg;

  localparam int LineSlots = 16;
  localparam int LineBytes = 512;

  localparam int KindW   = 2;
  localparam int ByteW   = 8;
  localparam int OffsetW = 9;
  localparam int LengthW = 9;

  localparam logic [KindW-1:0] KindRx      = 2'd0;
  localparam logic [KindW-1:0] KindRead    = 2'd1;
  localparam logic [KindW-1:0] KindRelease = 2'd2;

  localparam logic [ByteW-1:0] ChStatus  = 8'h25;
  localparam logic [ByteW-1:0] ChNewline = 8'h0A;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StLookup,
    StFinish
  } ula_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic lookup;
    logic finish;
  } ula_cmd_t;

endpackage

FILE: hw/rtl/ula_if.sv
// -----------------------------------------------------------------------------
// ula_if
// Request and response channels of the UART line assembler ring.
// -----------------------------------------------------------------------------
interface ula_in_if import ula_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [ByteW-1:0]   rx_byte;
  logic [OffsetW-1:0] read_offset;

  modport source(output valid, output kind, output rx_byte, output read_offset,
                 input ready);
  modport sink(input valid, input kind, input rx_byte, input read_offset,
               output ready);
endinterface

interface ula_out_if import ula_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               line_available;
  logic [LengthW-1:0] line_length;
  logic [ByteW-1:0]   read_data;
  logic               line_committed;
  logic               line_dropped;

  modport source(output valid, output line_available, output line_length,
                 output read_data, output line_committed, output line_dropped,
                 input ready);
  modport sink(input valid, input line_available, input line_length,
               input read_data, input line_committed, input line_dropped,
               output ready);
endinterface

FILE: hw/rtl/ula_ctrl.sv
// -----------------------------------------------------------------------------
// ula_ctrl
// Sequencer: capture a request, update state, look up the store, respond.
// -----------------------------------------------------------------------------
module ula_ctrl import ula_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_busy_i,
  output logic     in_ready_o,
  output ula_cmd_t cmd_o
);

  ula_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec:   state_d = StLookup;
      StLookup: state_d = StFinish;
      StFinish: begin
        // hold until the response register is free
        if (!out_busy_i) state_d = StIdle;
      end
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StExec:   cmd_o.exec   = 1'b1;
      StLookup: cmd_o.lookup = 1'b1;
      StFinish: cmd_o.finish = !out_busy_i;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ula_datapath.sv
// -----------------------------------------------------------------------------
// ula_datapath
// Line store, slot bookkeeping and response register.
// -----------------------------------------------------------------------------
module ula_datapath import ula_pkg::*; #(
  parameter int LINE_SLOTS = LineSlots,
  parameter int LINE_BYTES = LineBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ula_cmd_t           cmd_i,
  input  logic [KindW-1:0]   kind_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  logic [OffsetW-1:0] read_offset_i,
  input  logic               out_ready_i,
  output logic               out_busy_o,
  output logic               out_valid_o,
  output logic               line_available_o,
  output logic [LengthW-1:0] line_length_o,
  output logic [ByteW-1:0]   read_data_o,
  output logic               line_committed_o,
  output logic               line_dropped_o
);

  localparam int SlotW  = $clog2(LINE_SLOTS);
  localparam int FillW  = $clog2(LINE_BYTES);
  localparam int AddrW  = SlotW + FillW;
  localparam int CmpW   = (FillW > OffsetW) ? FillW : OffsetW;
  localparam int Depth  = 1 << AddrW;
  localparam int LenDepth = 1 << SlotW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(LINE_SLOTS - 1);
  localparam logic [FillW-1:0] LastFill = FillW'(LINE_BYTES - 1);

  // captured request
  logic [KindW-1:0]   kind_q;
  logic [ByteW-1:0]   byte_q;
  logic [OffsetW-1:0] off_q;

  // slot bookkeeping
  logic [LINE_SLOTS-1:0] ready_q, ready_d;
  logic [SlotW-1:0]      ws_q, ws_d, rs_q, rs_d, ws_next, rs_next;
  logic [FillW-1:0]      fill_q, fill_d, fill_inc;
  logic                  stat_q, stat_d;

  // memories
  logic [ByteW-1:0] store_mem [Depth];
  logic [FillW-1:0] len_mem   [LenDepth];
  logic [ByteW-1:0] store_rd_q;
  logic [FillW-1:0] len_rd_q;
  logic             avail_q;

  logic committed_q, dropped_q;
  logic out_valid_q;

  logic put, ends, clr_fill, commit, drop, release_slot;
  logic [CmpW-1:0] off_ext, len_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      byte_q <= rx_byte_i;
      off_q  <= read_offset_i;
    end
  end

  assign ws_next  = (ws_q == LastSlot) ? '0 : ws_q + 1'b1;
  assign rs_next  = (rs_q == LastSlot) ? '0 : rs_q + 1'b1;
  assign fill_inc = (fill_q == LastFill) ? '0 : fill_q + 1'b1;

  always_comb begin
    put      = 1'b0;
    ends     = 1'b0;
    clr_fill = 1'b0;
    stat_d   = stat_q;
    if (kind_q == KindRx) begin
      if (stat_q) begin
        if (byte_q == ChStatus) begin
          stat_d = 1'b0;
          ends   = 1'b1;
        end else begin
          put = 1'b1;
        end
      end else if (byte_q == ChStatus) begin
        // drop what was gathered and open a status message
        clr_fill = 1'b1;
        stat_d   = 1'b1;
      end else if (byte_q == ChNewline) begin
        ends = 1'b1;
      end else begin
        put = 1'b1;
      end
    end
  end

  assign commit       = ends && !ready_q[ws_next];
  assign drop         = ends && ready_q[ws_next];
  assign release_slot = (kind_q == KindRelease) && ready_q[rs_q];

  always_comb begin
    fill_d  = fill_q;
    ready_d = ready_q;
    ws_d    = ws_q;
    rs_d    = rs_q;
    if (put) begin
      fill_d = fill_inc;
    end else if (ends || clr_fill) begin
      fill_d = '0;
    end
    if (commit) begin
      ready_d[ws_q] = 1'b1;
      ws_d          = ws_next;
    end
    if (release_slot) begin
      ready_d[rs_q] = 1'b0;
      rs_d          = rs_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= '0;
      ws_q    <= '0;
      rs_q    <= '0;
      fill_q  <= '0;
      stat_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      ready_q <= ready_d;
      ws_q    <= ws_d;
      rs_q    <= rs_d;
      fill_q  <= fill_d;
      stat_q  <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      committed_q <= commit;
      dropped_q   <= drop;
    end
  end

  assign off_ext = CmpW'(off_q);

  // line store: write during update, read during lookup
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && put) begin
      store_mem[{ws_q, fill_q}] <= byte_q;
    end
    if (cmd_i.lookup) begin
      store_rd_q <= store_mem[{rs_q, off_ext[FillW-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && commit) begin
      len_mem[ws_q] <= fill_q;
    end
    if (cmd_i.lookup) begin
      len_rd_q <= len_mem[rs_q];
      avail_q  <= ready_q[rs_q];
    end
  end

  assign len_ext = CmpW'(len_rd_q);

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      line_available_o <= avail_q;
      line_length_o    <= avail_q ? len_ext[LengthW-1:0] : '0;
      read_data_o      <= ((kind_q == KindRead) && avail_q && (off_ext < len_ext))
                          ? store_rd_q : '0;
      line_committed_o <= committed_q;
      line_dropped_o   <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_busy_o  = out_valid_q && !out_ready_i;

endmodule

FILE: hw/rtl/uart_line_assembler_ring.sv
// -----------------------------------------------------------------------------
// uart_line_assembler_ring
// Gathers received UART bytes into a ring of line slots and serves byte
// reads and releases of the oldest ready line.
// -----------------------------------------------------------------------------
//
//   channel  port   dir   carries
//   -------  -----  ----  ------------------------------------------------
//   request  req_i  sink  kind, rx_byte, read_offset
//   response rsp_o  src   line_available, line_length, read_data,
//                         line_committed, line_dropped
//
// One request at a time: accept, update, lookup, finish. The single-port
// line store sets this order: it is written in the update cycle and read
// in the lookup cycle.
// A waiting response stalls the sequencer in its finish cycle only.
// Reset clears the slot ready bits and pointers at once; the line store and
// the length table start undefined and need no clearing pass.
//
module uart_line_assembler_ring import ula_pkg::*; #(
  parameter int LINE_SLOTS = LineSlots,
  parameter int LINE_BYTES = LineBytes
) (
  input  logic clk_i,
  input  logic rst_ni,
  ula_in_if.sink    req_i,
  ula_out_if.source rsp_o
);

  ula_cmd_t cmd;
  logic     out_busy;

  // sequencer: advance one phase per cycle, wait in idle for a request, hold in finish while blocked
  ula_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .out_busy_i (out_busy),
    .in_ready_o (req_i.ready),
    .cmd_o      (cmd)
  );

  // datapath: line store, slot ring state and the response register
  ula_datapath #(
    .LINE_SLOTS (LINE_SLOTS),
    .LINE_BYTES (LINE_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (req_i.kind),
    .rx_byte_i        (req_i.rx_byte),
    .read_offset_i    (req_i.read_offset),
    .out_ready_i      (rsp_o.ready),
    .out_busy_o       (out_busy),
    .out_valid_o      (rsp_o.valid),
    .line_available_o (rsp_o.line_available),
    .line_length_o    (rsp_o.line_length),
    .read_data_o      (rsp_o.read_data),
    .line_committed_o (rsp_o.line_committed),
    .line_dropped_o   (rsp_o.line_dropped)
  );

endmodule

FILE: hw/rtl/ula_checker.sv
// -----------------------------------------------------------------------------
// ula_checker
// Port-level checks of the UART line assembler ring.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ula_checker import ula_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               line_available_i,
  input logic [LengthW-1:0] line_length_i,
  input logic [ByteW-1:0]   read_data_i,
  input logic               line_committed_i,
  input logic               line_dropped_i
);

  // one request in flight: no acceptance in the cycle after one
  `ULA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // a line end is either stored or dropped, never both
  `ULA_ASSERT(a_commit_xor_drop, clk_i, rst_ni,
              !(out_valid_i && line_committed_i && line_dropped_i))
  // data and length only come from a ready line
  `ULA_ASSERT(a_empty_reads_zero, clk_i, rst_ni,
              !(out_valid_i && !line_available_i &&
                (read_data_i != '0 || line_length_i != '0)))
  // a stalled response holds
  `ULA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(line_length_i) && $stable(read_data_i))

endmodule

bind uart_line_assembler_ring ula_checker u_ula_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .line_available_i (rsp_o.line_available),
  .line_length_i    (rsp_o.line_length),
  .read_data_i      (rsp_o.read_data),
  .line_committed_i (rsp_o.line_committed),
  .line_dropped_i   (rsp_o.line_dropped)
);
